@@ hdl/pdw_pkg.sv @@
package pdw_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_done;
    } out_t;

    // Results of one input transaction, handed from decoder to serializer.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  count;
        logic                        eom;
    } group_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd97 && c <= 8'd102) ||
               (c >= 8'd65 && c <= 8'd70);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            v = c - 8'd48;
        end else if (c >= 8'd97 && c <= 8'd102) begin
            v = c - 8'd87;
        end else if (c >= 8'd65 && c <= 8'd70) begin
            v = c - 8'd55;
        end
        return v[3:0];
    endfunction

    function automatic logic keep_literal(input logic [7:0] v);
        return (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
               (v >= 8'd65 && v <= 8'd90) || v == 8'h21 || v == 8'h24 ||
               (v >= 8'h26 && v <= 8'h2F) || v == 8'h3A || v == 8'h3B ||
               v == 8'h3D || v == 8'h3F || v == 8'h40 || v == 8'h5F;
    endfunction

endpackage

@@ hdl/percent_decoder_whitelist.sv @@
// Registers: the input register holds a transaction, then the serializer register its results.
// Throughput: one input transaction per cycle while each yields at most one result and
// m_ready stays high; a transaction with k results (k up to 3) holds the output register
// until the one-result-per-cycle serializer has sent all k. Results of zero take no output slot.
// Reset (aresetn low, synchronous): both stages empty, nothing pending, held digit zero.
module percent_decoder_whitelist (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pdw_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pdw_pkg::out_t m_data
);

    logic            in_valid_reg;
    pdw_pkg::in_t    in_data_reg;
    pdw_pkg::phase_t phase_reg;
    logic [7:0]      held_reg;
    pdw_pkg::phase_t phase_next;
    logic [7:0]      held_next;
    pdw_pkg::group_t grp;
    logic            grp_valid;
    logic            grp_ready;
    logic            in_consume;

    // Drop the input register once its results are handed over (or there are none).
    assign in_consume = in_valid_reg && (grp.count == 2'd0 || grp_ready);
    assign grp_valid  = in_valid_reg && grp.count != 2'd0;
    assign s_ready    = !in_valid_reg || in_consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= pdw_pkg::PH_IDLE;
            held_reg     <= 8'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (in_consume) begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    pdw_decode u_decode (
        .phase_reg  (phase_reg),
        .held_reg   (held_reg),
        .in_data    (in_data_reg),
        .phase_next (phase_next),
        .held_next  (held_next),
        .grp        (grp)
    );

    pdw_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ hdl/pdw_decode.sv @@
module pdw_decode (
    input  pdw_pkg::phase_t phase_reg,
    input  logic [7:0]      held_reg,
    input  pdw_pkg::in_t    in_data,
    output pdw_pkg::phase_t phase_next,
    output logic [7:0]      held_next,
    output pdw_pkg::group_t grp
);

    logic [7:0]      c;
    logic            c_hex;
    logic [7:0]      esc_val;
    pdw_pkg::phase_t phase_mid;
    logic [7:0]      held_mid;
    logic [pdw_pkg::MAX_RESULTS-1:0][7:0] b;
    logic [1:0]      n;

    assign c       = in_data.in_byte;
    assign c_hex   = pdw_pkg::is_hex(c);
    assign esc_val = {pdw_pkg::hex_val(held_reg), pdw_pkg::hex_val(c)};

    // State after the byte itself, before the end-of-message flush.
    always_comb begin
        phase_mid = (c == pdw_pkg::CH_PERCENT) ? pdw_pkg::PH_PCT : pdw_pkg::PH_IDLE;
        held_mid  = 8'd0;
        unique case (phase_reg)
            pdw_pkg::PH_PCT: begin
                if (c_hex) begin
                    phase_mid = pdw_pkg::PH_DIGIT;
                    held_mid  = c;
                end else begin
                    held_mid = held_reg;
                end
            end
            pdw_pkg::PH_DIGIT: begin
                if (c_hex) begin
                    phase_mid = pdw_pkg::PH_IDLE;
                end
            end
            default: begin
                held_mid = held_reg;
            end
        endcase
    end

    always_comb begin
        if (in_data.end_of_message) begin
            phase_next = pdw_pkg::PH_IDLE;
            held_next  = 8'd0;
        end else begin
            phase_next = phase_mid;
            held_next  = held_mid;
        end
    end

    // Append results in order; at most three can arise.
    always_comb begin
        b = '0;
        n = 2'd0;
        unique case (phase_reg)
            pdw_pkg::PH_PCT: begin
                if (!c_hex) begin
                    b[n] = pdw_pkg::CH_PERCENT;
                    n    = n + 2'd1;
                    if (c == pdw_pkg::CH_PLUS) begin
                        b[n] = pdw_pkg::CH_SPACE;
                        n    = n + 2'd1;
                    end else if (c != pdw_pkg::CH_PERCENT) begin
                        b[n] = c;
                        n    = n + 2'd1;
                    end
                end
            end
            pdw_pkg::PH_DIGIT: begin
                if (c_hex) begin
                    if (!pdw_pkg::keep_literal(esc_val)) begin
                        b[0] = esc_val;
                        n    = 2'd1;
                    end else begin
                        b[0] = pdw_pkg::CH_PERCENT;
                        b[1] = held_reg;
                        b[2] = c;
                        n    = 2'd3;
                    end
                end else begin
                    b[0] = pdw_pkg::CH_PERCENT;
                    b[1] = held_reg;
                    n    = 2'd2;
                    if (c == pdw_pkg::CH_PLUS) begin
                        b[2] = pdw_pkg::CH_SPACE;
                        n    = 2'd3;
                    end else if (c != pdw_pkg::CH_PERCENT) begin
                        b[2] = c;
                        n    = 2'd3;
                    end
                end
            end
            default: begin
                if (c == pdw_pkg::CH_PLUS) begin
                    b[0] = pdw_pkg::CH_SPACE;
                    n    = 2'd1;
                end else if (c != pdw_pkg::CH_PERCENT) begin
                    b[0] = c;
                    n    = 2'd1;
                end
            end
        endcase

        // Flush whatever is still pending at the end of the message.
        if (in_data.end_of_message) begin
            if (phase_mid == pdw_pkg::PH_PCT && n < 2'd3) begin
                b[n] = pdw_pkg::CH_PERCENT;
                n    = n + 2'd1;
            end else if (phase_mid == pdw_pkg::PH_DIGIT) begin
                if (n < 2'd3) begin
                    b[n] = pdw_pkg::CH_PERCENT;
                    n    = n + 2'd1;
                end
                if (n < 2'd3) begin
                    b[n] = held_mid;
                    n    = n + 2'd1;
                end
            end
        end
    end

    assign grp.bytes = b;
    assign grp.count = n;
    assign grp.eom   = in_data.end_of_message;

endmodule

@@ hdl/pdw_serializer.sv @@
module pdw_serializer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            grp_valid,
    output logic            grp_ready,
    input  pdw_pkg::group_t grp,
    output logic            m_valid,
    input  logic            m_ready,
    output pdw_pkg::out_t   m_data
);

    logic                                     valid_reg;
    logic [1:0]                               idx_reg;
    logic [pdw_pkg::MAX_RESULTS-1:0][7:0]     bytes_reg;
    logic [1:0]                               cnt_reg;
    logic                                     eom_reg;
    logic                                     is_last;
    logic                                     load;

    assign is_last   = (idx_reg == cnt_reg - 2'd1);
    assign grp_ready = !valid_reg || (m_ready && is_last);
    assign load      = grp_valid && grp_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_ready) begin
            if (is_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= grp.bytes;
            cnt_reg   <= grp.count;
            eom_reg   <= grp.eom;
        end
    end

    assign m_valid             = valid_reg;
    assign m_data.out_byte     = bytes_reg[idx_reg];
    assign m_data.run_last     = is_last;
    assign m_data.message_done = is_last && eom_reg;

endmodule

@@ tb/percent_decoder_whitelist_tb.sv @@
module percent_decoder_whitelist_tb;

    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned REPORT_MAX   = 10;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    pdw_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    pdw_pkg::out_t m_data;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // decoder state as seen by the predictor
    pdw_pkg::phase_t dec_phase = pdw_pkg::PH_IDLE;
    logic [7:0]      dec_held  = 8'h00;

    pdw_pkg::out_t expected_chars[$];

    int unsigned mismatches      = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned messages_done   = 0;
    int unsigned idle_cycles     = 0;

    percent_decoder_whitelist dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] t;
        if (c <= "9") begin
            t = c - "0";
        end else if (c >= "a") begin
            t = c - "a" + 8'd10;
        end else begin
            t = c - "A" + 8'd10;
        end
        return t[3:0];
    endfunction

    // alphanumerics and the reserved punctuation stay escaped
    function automatic logic stays_literal(input logic [7:0] v);
        return (v >= "0" && v <= "9") || (v >= "a" && v <= "z") || (v >= "A" && v <= "Z") ||
               v == "!" || v == "$" || (v >= "&" && v <= "/") || v == ":" || v == ";" ||
               v == "=" || v == "?" || v == "@" || v == "_";
    endfunction

    function automatic void predict_decoded_chars(input pdw_pkg::in_t item);
        logic [7:0]    c;
        logic [7:0]    val;
        logic [7:0]    outs[$];
        logic          do_plain;
        int            n;
        pdw_pkg::out_t r;
        c        = item.in_byte;
        do_plain = 1'b0;
        case (dec_phase)
            pdw_pkg::PH_PCT: begin
                if (hex_char(c)) begin
                    dec_held  = c;
                    dec_phase = pdw_pkg::PH_DIGIT;
                end else begin
                    outs.push_back(pdw_pkg::CH_PERCENT);
                    do_plain = 1'b1;
                end
            end
            pdw_pkg::PH_DIGIT: begin
                if (hex_char(c)) begin
                    val = {hex_nibble(dec_held), hex_nibble(c)};
                    if (!stays_literal(val)) begin
                        outs.push_back(val);
                    end else begin
                        outs.push_back(pdw_pkg::CH_PERCENT);
                        outs.push_back(dec_held);
                        outs.push_back(c);
                    end
                    dec_phase = pdw_pkg::PH_IDLE;
                end else begin
                    outs.push_back(pdw_pkg::CH_PERCENT);
                    outs.push_back(dec_held);
                    do_plain = 1'b1;
                end
                dec_held = 8'h00;
            end
            default: do_plain = 1'b1;
        endcase
        // a breaking byte is decoded as if nothing were pending
        if (do_plain) begin
            dec_phase = pdw_pkg::PH_IDLE;
            if (c == pdw_pkg::CH_PLUS) begin
                outs.push_back(pdw_pkg::CH_SPACE);
            end else if (c == pdw_pkg::CH_PERCENT) begin
                dec_phase = pdw_pkg::PH_PCT;
            end else begin
                outs.push_back(c);
            end
        end
        if (item.end_of_message) begin
            if (dec_phase == pdw_pkg::PH_PCT) begin
                outs.push_back(pdw_pkg::CH_PERCENT);
            end else if (dec_phase == pdw_pkg::PH_DIGIT) begin
                outs.push_back(pdw_pkg::CH_PERCENT);
                outs.push_back(dec_held);
            end
            dec_phase = pdw_pkg::PH_IDLE;
            dec_held  = 8'h00;
        end
        n = (outs.size() > pdw_pkg::MAX_RESULTS) ? pdw_pkg::MAX_RESULTS : outs.size();
        for (int k = 0; k < n; k++) begin
            r.out_byte     = outs[k];
            r.run_last     = (k == n - 1);
            r.message_done = (k == n - 1) && item.end_of_message;
            expected_chars.push_back(r);
        end
    endfunction

    function automatic logic [7:0] rand_hex();
        string digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        pdw_pkg::out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (m_data.message_done) begin
                messages_done++;
            end
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: out_byte=%02h run_last=%0b message_done=%0b",
                             m_data.out_byte, m_data.run_last, m_data.message_done);
                end
            end else begin
                exp_r = expected_chars.pop_front();
                if (m_data.out_byte !== exp_r.out_byte || m_data.run_last !== exp_r.run_last ||
                    m_data.message_done !== exp_r.message_done) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch: out_byte exp %02h got %02h, run_last exp %0b got %0b, %s",
                                 exp_r.out_byte, m_data.out_byte, exp_r.run_last,
                                 m_data.run_last,
                                 $sformatf("message_done exp %0b got %0b",
                                           exp_r.message_done, m_data.message_done));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transaction for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] b, input logic eom);
        pdw_pkg::in_t item;
        item.in_byte        = b;
        item.end_of_message = eom;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_decoded_chars(item);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt, input logic eom_on_last);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], eom_on_last && (i == txt.len() - 1));
        end
    endtask

    task automatic test_plain_bytes();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(pdw_pkg::CH_PLUS, 1'b0);
        send_char("z", 1'b1);
    endtask

    task automatic test_escapes();
        send_text("%41", 1'b0);   // kept: passes through as three characters
        send_text("%20", 1'b0);
        send_text("%fF", 1'b0);
        send_text("%2B", 1'b1);   // plus sign is kept, not turned into a space
    endtask

    task automatic test_broken_escapes();
        send_text("%G", 1'b0);
        send_text("%4%", 1'b0);   // the second percent opens a new escape
        send_char(8'h80, 1'b1);
    endtask

    task automatic test_end_flush();
        send_text("%", 1'b1);
        send_text("%a", 1'b1);
    endtask

    // Mostly well-formed escapes with random content, plus noise.
    task automatic send_random_messages(input int unsigned count);
        logic [7:0]  msg[$];
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        sent = 0;
        while (sent < count) begin
            msg.delete();
            len = $urandom_range(12, 1);
            while (msg.size() < len) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    msg.push_back(pdw_pkg::CH_PERCENT);
                    msg.push_back(rand_hex());
                    msg.push_back(rand_hex());
                    if ($urandom_range(99) < 15) begin
                        msg[msg.size() - 1 - $urandom_range(1)] = 8'($urandom_range(255));
                    end
                end else if (pick < 55) begin
                    msg.push_back(pdw_pkg::CH_PLUS);
                end else if (pick < 60) begin
                    msg.push_back(pdw_pkg::CH_PERCENT);
                end else begin
                    msg.push_back(8'($urandom_range(255)));
                end
            end
            for (int i = 0; i < msg.size(); i++) begin
                send_char(msg[i], i == msg.size() - 1);
                sent++;
            end
        end
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_messages(64);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct  = 87;
        recv_stall_pct = 0;
        send_random_messages(64);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        send_random_messages(64);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        send_random_messages(64);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_plain_bytes();
        test_escapes();
        test_broken_escapes();
        test_end_flush();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        s_valid <= 1'b0;

        while (expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_chars.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", expected_chars.size());
        end

        $display("Decoded %0d input bytes into %0d checked characters over %0d messages,",
                 items_sent, results_checked, messages_done);
        $display("covering kept, decoded, broken and flushed escapes under four pacing modes.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
